// ----- rtl/core/distinct_hue_color_generator_top_assert.svh -----
// ----------------------------------------------------------------------------
// distinct_hue_color_generator_top_assert
// Assertion macros for the distinct hue color generator.
// ----------------------------------------------------------------------------
// both expect clk and rst_n in scope; the body is skipped while reset is low
`ifndef DISTINCT_HUE_COLOR_GENERATOR_TOP_ASSERT_SVH
`define DISTINCT_HUE_COLOR_GENERATOR_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DHCG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DHCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dhcg_pkg.sv -----
// ----------------------------------------------------------------------------
// dhcg_pkg
// Shared constants, register indexes, state and sector codes and the result
// record of the distinct hue color generator.
// ----------------------------------------------------------------------------
package dhcg_pkg;

  // default sizing
  localparam int MAX_LEVEL_DEF = 12;
  localparam int HUE_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH   = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_HUE   = 2'd0,
    REG_ALPHA      = 2'd1,
    REG_SATURATION = 2'd2,
    REG_BRIGHTNESS = 2'd3
  } cfg_reg_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HUE,
    BK_SECT,
    BK_CONV,
    BK_EMIT
  } back_state_t;

  // hue sextant of the color wheel
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // one finished color
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] hue;
  } res_t;

endpackage

// ----- rtl/core/dhcg_fifo.sv -----
// ----------------------------------------------------------------------------
// dhcg_fifo
// Small register queue between the request front end and the color back end.
// ----------------------------------------------------------------------------
module dhcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dhcg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/dhcg_front.sv -----
// ----------------------------------------------------------------------------
// dhcg_front
// Takes request beats, drops empty ones and walks the triad / position / level
// iterator, queueing a snapshot of it for every color asked for.
// ----------------------------------------------------------------------------
module dhcg_front #(
  parameter int MAX_LEVEL = dhcg_pkg::MAX_LEVEL_DEF,
  parameter int POS_W     = MAX_LEVEL,
  parameter int LVL_W     = $clog2(MAX_LEVEL + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic             in_request,
  input  logic             q_full,
  output logic             q_push,
  output logic [1:0]       q_triad,
  output logic [POS_W-1:0] q_pos,
  output logic [LVL_W-1:0] q_lvl
);

  logic [1:0]       triad_r, triad_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [POS_W:0]   pos_inc;
  logic [LVL_W-1:0] lvl_inc;

  assign q_push  = in_push && !q_full && in_request;
  assign q_triad = triad_r;
  assign q_pos   = pos_r;
  assign q_lvl   = lvl_r;

  // iterator advance: triad, then position, then level, then restart
  always_comb begin
    pos_inc   = {1'b0, pos_r} + ((lvl_r == LVL_W'(1)) ? (POS_W+1)'(1) : (POS_W+1)'(2));
    lvl_inc   = lvl_r + 1'b1;
    triad_nxt = triad_r;
    pos_nxt   = pos_r;
    lvl_nxt   = lvl_r;
    if (triad_r != 2'd2) begin
      triad_nxt = triad_r + 1'b1;
    end else begin
      triad_nxt = 2'd0;
      if ((pos_inc >> lvl_r) == '0) begin
        pos_nxt = pos_inc[POS_W-1:0];
      end else if (lvl_inc > LVL_W'(MAX_LEVEL)) begin
        pos_nxt = '0;
        lvl_nxt = LVL_W'(1);
      end else begin
        pos_nxt = POS_W'(1);
        lvl_nxt = lvl_inc;
      end
    end
  end

  // iterator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      triad_r <= 2'd0;
      pos_r   <= '0;
      lvl_r   <= LVL_W'(1);
    end else if (q_push) begin
      triad_r <= triad_nxt;
      pos_r   <= pos_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

// ----- rtl/core/dhcg_back.sv -----
// ----------------------------------------------------------------------------
// dhcg_back
// Turns one iterator snapshot into a hue and an RGB color: hue sum, sextant
// split, a three-deep multiply pipeline for the p/q/t factors, then the
// output register that holds the color until it is popped.
// ----------------------------------------------------------------------------
module dhcg_back #(
  parameter int HUE_BITS = dhcg_pkg::HUE_BITS_DEF,
  parameter int POS_W    = dhcg_pkg::MAX_LEVEL_DEF,
  parameter int LVL_W    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // queue head
  input  logic                q_empty,
  input  logic [1:0]          q_triad,
  input  logic [POS_W-1:0]    q_pos,
  input  logic [LVL_W-1:0]    q_lvl,
  output logic                q_pop,
  // configuration
  input  logic [15:0]         base_hue,
  input  logic [7:0]          alpha_level,
  input  logic [7:0]          saturation,
  input  logic [7:0]          brightness,
  // result
  output logic                out_valid,
  input  logic                out_pop,
  output dhcg_pkg::res_t      res
);

  localparam int HB     = HUE_BITS;
  localparam int MUL_W  = HB + POS_W;
  localparam logic [HB-1:0]   THIRD    = HB'((1 << HB) / 3);
  localparam logic [HB:0]     ONE      = (HB+1)'(1) << HB;
  localparam logic [HB+7:0]   D_FULL   = (HB+8)'(255) << HB;
  localparam logic [HB+15:0]  D_HALF   = (HB+16)'(D_FULL >> 1);
  localparam logic [2:0]      CH_P     = 3'd0;
  localparam logic [2:0]      CH_Q     = 3'd1;
  localparam logic [2:0]      CH_LAST  = 3'd4;

  dhcg_pkg::back_state_t state_r, state_nxt;

  logic [1:0]       triad_r;
  logic [LVL_W-1:0] lvl_r;
  logic [MUL_W-1:0] mult_r;
  logic [HB-1:0]    hue_r;
  logic [2:0]       sector_r;
  logic [HB-1:0]    f_r;
  logic [2:0]       cnt_r;
  logic [HB+8:0]    m1_r;
  logic [HB+15:0]   m2_r;
  logic [7:0]       chan_r [3];
  logic             out_valid_r;
  dhcg_pkg::res_t   res_r;

  logic             out_free;
  logic             emit_load;
  logic [HB-1:0]    triad_off;
  logic [HB-1:0]    hue_sum;
  logic [HB+2:0]    h6;
  logic [HB:0]      g_sel;
  logic [HB+7:0]    diff;
  logic [7:0]       r_sel, g_out, b_sel;

  // floor(z / 255) for z below 255 * 256
  function automatic logic [7:0] div255(input logic [15:0] z);
    logic [16:0] acc;
    acc = {1'b0, z} + 17'd1 + 17'(z[15:8]);
    return acc[15:8];
  endfunction

  assign out_free  = !out_valid_r || out_pop;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // sequencer next state and handshakes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      dhcg_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = dhcg_pkg::BK_HUE;
        end
      end
      dhcg_pkg::BK_HUE:  state_nxt = dhcg_pkg::BK_SECT;
      dhcg_pkg::BK_SECT: state_nxt = dhcg_pkg::BK_CONV;
      dhcg_pkg::BK_CONV: begin
        if (cnt_r == CH_LAST) begin
          state_nxt = dhcg_pkg::BK_EMIT;
        end
      end
      dhcg_pkg::BK_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          state_nxt = dhcg_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dhcg_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhcg_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hue sum and sextant split
  always_comb begin
    case (triad_r)
      2'd0:    triad_off = '0;
      2'd1:    triad_off = THIRD;
      default: triad_off = HB'({THIRD, 1'b0});
    endcase
    hue_sum = HB'(base_hue) + triad_off + HB'(mult_r >> lvl_r);
    h6      = {1'b0, hue_r, 2'b00} + {2'b00, hue_r, 1'b0};
  end

  // channel factor for the current pipeline slot, and 1 - s*g
  always_comb begin
    case (cnt_r)
      CH_P:    g_sel = ONE;
      CH_Q:    g_sel = {1'b0, f_r};
      default: g_sel = ONE - {1'b0, f_r};
    endcase
    diff = D_FULL - (HB+8)'(m1_r);
  end

  // sextant to rgb mapping of v, p, q, t
  always_comb begin
    case (sector_r)
      dhcg_pkg::SEC_RED_YEL: begin
        r_sel = brightness; g_out = chan_r[2]; b_sel = chan_r[0];
      end
      dhcg_pkg::SEC_YEL_GRN: begin
        r_sel = chan_r[1]; g_out = brightness; b_sel = chan_r[0];
      end
      dhcg_pkg::SEC_GRN_CYN: begin
        r_sel = chan_r[0]; g_out = brightness; b_sel = chan_r[2];
      end
      dhcg_pkg::SEC_CYN_BLU: begin
        r_sel = chan_r[0]; g_out = chan_r[1]; b_sel = brightness;
      end
      dhcg_pkg::SEC_BLU_MAG: begin
        r_sel = chan_r[2]; g_out = chan_r[0]; b_sel = brightness;
      end
      default: begin
        r_sel = brightness; g_out = chan_r[0]; b_sel = chan_r[1];
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      dhcg_pkg::BK_IDLE: begin
        triad_r <= q_triad;
        lvl_r   <= q_lvl;
        mult_r  <= MUL_W'(THIRD) * MUL_W'(q_pos);
      end
      dhcg_pkg::BK_HUE: begin
        hue_r <= hue_sum;
      end
      dhcg_pkg::BK_SECT: begin
        sector_r <= h6[HB+2:HB];
        f_r      <= h6[HB-1:0];
        cnt_r    <= '0;
      end
      dhcg_pkg::BK_CONV: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r < 3'd3) begin
          m1_r <= (HB+9)'(saturation) * (HB+9)'(g_sel);
        end
        if (cnt_r != 3'd0 && cnt_r < CH_LAST) begin
          m2_r <= (HB+16)'(brightness) * (HB+16)'(diff) + D_HALF;
        end
        if (cnt_r >= 3'd2) begin
          chan_r[2'(cnt_r - 3'd2)] <= div255(m2_r[HB+15:HB]);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      res_r.red   <= r_sel;
      res_r.green <= g_out;
      res_r.blue  <= b_sel;
      res_r.alpha <= alpha_level;
      res_r.hue   <= 16'(hue_r);
    end
  end

endmodule

// ----- rtl/core/distinct_hue_color_generator_top.sv -----
// ----------------------------------------------------------------------------
// distinct_hue_color_generator_top
// Request-driven palette source of well separated hues as 8-bit RGBA.
// ----------------------------------------------------------------------------
// Every push with in_request high yields one color; a push with in_request
// low is taken and dropped. The front end takes one request beat per cycle
// into a two-entry queue, so in_full only rises when colors are asked for
// faster than they are made. Each color passes the back end in order: the
// position is loaded and multiplied, then the hue sum, the sextant split,
// the shared two-multiplier pipeline that forms the p, q and t factors,
// and the output register load. The sequencer sets the sustained rate and
// pops no new snapshot until the last color is loaded. A finished color waits
// in the output register while the next one is already being computed.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module distinct_hue_color_generator_top #(
  parameter int MAX_LEVEL = dhcg_pkg::MAX_LEVEL_DEF,
  parameter int HUE_BITS  = dhcg_pkg::HUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_request,
  // color channel
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha_out,
  output logic [15:0]                     out_hue_out,
  // configuration
  input  logic                            cfg_we,
  input  logic [dhcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhcg_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "distinct_hue_color_generator_top_assert.svh"

  localparam int POS_W = MAX_LEVEL;
  localparam int LVL_W = $clog2(MAX_LEVEL + 2);
  localparam int Q_W   = 2 + POS_W + LVL_W;

  logic [15:0] base_r;
  logic [7:0]  alpha_r, sat_r, bright_r;

  logic             q_push, q_full, q_pop, q_empty;
  logic [1:0]       f_triad, b_triad;
  logic [POS_W-1:0] f_pos, b_pos;
  logic [LVL_W-1:0] f_lvl, b_lvl;
  logic [Q_W-1:0]   q_wdata, q_rdata;
  logic             res_valid;
  dhcg_pkg::res_t   res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      alpha_r  <= 8'hFF;
      sat_r    <= 8'hFF;
      bright_r <= 8'hFF;
    end else if (cfg_we) begin
      case (dhcg_pkg::cfg_reg_t'(cfg_index))
        dhcg_pkg::REG_BASE_HUE:   base_r   <= cfg_data[15:0];
        dhcg_pkg::REG_ALPHA:      alpha_r  <= cfg_data[7:0];
        dhcg_pkg::REG_SATURATION: sat_r    <= cfg_data[7:0];
        dhcg_pkg::REG_BRIGHTNESS: bright_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // request front end
  dhcg_front #(
    .MAX_LEVEL (MAX_LEVEL),
    .POS_W     (POS_W),
    .LVL_W     (LVL_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_request (in_request),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_triad    (f_triad),
    .q_pos      (f_pos),
    .q_lvl      (f_lvl)
  );

  assign q_wdata = {f_triad, f_pos, f_lvl};
  assign in_full = q_full;

  // snapshot queue
  dhcg_fifo #(
    .WIDTH (Q_W),
    .DEPTH (dhcg_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_triad, b_pos, b_lvl} = q_rdata;

  // color back end
  dhcg_back #(
    .HUE_BITS (HUE_BITS),
    .POS_W    (POS_W),
    .LVL_W    (LVL_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_triad     (b_triad),
    .q_pos       (b_pos),
    .q_lvl       (b_lvl),
    .q_pop       (q_pop),
    .base_hue    (base_r),
    .alpha_level (alpha_r),
    .saturation  (sat_r),
    .brightness  (bright_r),
    .out_valid   (res_valid),
    .out_pop     (out_pop),
    .res         (res)
  );

  assign out_empty     = !res_valid;
  assign out_red       = res.red;
  assign out_green     = res.green;
  assign out_blue      = res.blue;
  assign out_alpha_out = res.alpha;
  assign out_hue_out   = res.hue;

  // checks
  `DHCG_ASSERT_SAME(a_queue_no_overflow, q_push, !q_full, "snapshot pushed into full queue")
  `DHCG_ASSERT_SAME(a_queue_no_underrun, q_pop, !q_empty, "back end popped empty queue")
  `DHCG_ASSERT_NEXT(a_empty_beat_holds_iter, in_push && !in_full && !in_request,
                    $stable(q_wdata), "beat without request moved the iterator")

endmodule

// ----- verif/distinct_hue_color_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// distinct_hue_color_generator_top_tb
// Self-checking bench for the distinct hue color generator. A scripted
// opening covers reset colors, dropped requests, register extremes and hue
// wrap. Randomized register settings and request traffic follow, with stalls
// on both sides. A final stretch of back-to-back requests closes the run.
// Every color beat is checked against an in-bench model of the hue iterator
// and the HSV to RGB conversion, or against a scripted color.
// ----------------------------------------------------------------------------
module distinct_hue_color_generator_top_tb;

  localparam int HUE_W = dhcg_pkg::HUE_BITS_DEF;
  localparam int LAST_LEVEL = dhcg_pkg::MAX_LEVEL_DEF;
  localparam int IDX_W = dhcg_pkg::CFG_IDX_W;
  localparam int DATA_W = dhcg_pkg::CFG_DATA_W;
  localparam longint unsigned HUE_ONE = 64'd1 << HUE_W;
  localparam longint unsigned HUE_MASK = HUE_ONE - 64'd1;
  localparam longint unsigned HUE_THIRD = HUE_ONE / 64'd3;
  localparam longint unsigned FULL_SCALE = 64'd255 * HUE_ONE;
  localparam int SETTLE = 30;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 60;
  localparam int TAIL_ITEMS = 60;
  localparam int MAX_SHOWN = 10;
  localparam longint WATCHDOG = 64'd6_000_000;
  localparam int NROWS = 32;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    dhcg_pkg::cfg_reg_t reg_sel;
    logic [DATA_W-1:0]  wdata;
    logic               req;
    logic               typed;
    dhcg_pkg::res_t     color;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_request;
  logic              out_empty;
  logic              out_pop;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic [7:0]        out_alpha_out;
  logic [15:0]       out_hue_out;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // register copies and iterator state of the color model
  logic [15:0] base_hue_m;
  logic [7:0]  alpha_m;
  logic [7:0]  sat_m;
  logic [7:0]  bright_m;
  logic [1:0]  triad_m;
  logic [11:0] pos_m;
  logic [3:0]  level_m;

  dhcg_pkg::res_t pending_colors[$];
  int unsigned    n_bad;
  bit             gaps_on;
  bit             hold_req;

  // scripted opening
  script_row_t script [NROWS] = '{
    // first colors after reset: pure red, green, blue
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b1,
      '{8'd255, 8'd0, 8'd0, 8'd255, 16'd0}},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b1,
      '{8'd0, 8'd255, 8'd0, 8'd255, 16'd21845}},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b1,
      '{8'd0, 8'd0, 8'd255, 8'd255, 16'd43690}},
    // request low gives no color and leaves the iterator alone
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    // no saturation, transparent: white
    '{ROW_REG, dhcg_pkg::REG_SATURATION, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_ALPHA, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    // no brightness: black
    '{ROW_REG, dhcg_pkg::REG_BRIGHTNESS, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    // full saturation at half brightness
    '{ROW_REG, dhcg_pkg::REG_SATURATION, 16'd255, 1'b0, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_BRIGHTNESS, 16'd128, 1'b0, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_ALPHA, 16'd255, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b0, 1'b0, '0},
    // base at the top of the turn: hue sum wraps
    '{ROW_REG, dhcg_pkg::REG_BASE_HUE, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    // alternating bits on the base
    '{ROW_REG, dhcg_pkg::REG_BASE_HUE, 16'hAAAA, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    // smallest nonzero saturation and brightness
    '{ROW_REG, dhcg_pkg::REG_SATURATION, 16'd1, 1'b0, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_BRIGHTNESS, 16'd1, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_BASE_HUE, 16'h5555, 1'b0, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_SATURATION, 16'd255, 1'b0, 1'b0, '0},
    '{ROW_REG, dhcg_pkg::REG_BRIGHTNESS, 16'd255, 1'b0, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_ITEM, dhcg_pkg::REG_BASE_HUE, 16'd0, 1'b1, 1'b0, '0}
  };

  distinct_hue_color_generator_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_request    (in_request),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out),
    .out_hue_out   (out_hue_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one channel value: v * (1 - s * g), rounded half up
  function automatic logic [7:0] shade(longint unsigned v, longint unsigned s,
                                       longint unsigned g);
    longint unsigned lvl;
    lvl = (v * (FULL_SCALE - s * g) + FULL_SCALE / 64'd2) / FULL_SCALE;
    return lvl[7:0];
  endfunction

  // color for the current iterator position, then step the iterator
  function automatic dhcg_pkg::res_t next_color();
    longint unsigned   hue;
    longint unsigned   h6;
    longint unsigned   frac;
    logic [7:0]        v;
    logic [7:0]        p;
    logic [7:0]        q;
    logic [7:0]        t;
    dhcg_pkg::sector_t sec;
    int unsigned       nxt_pos;
    dhcg_pkg::res_t    c;
    hue = (64'(base_hue_m) + HUE_THIRD * 64'(triad_m)
           + ((HUE_THIRD * 64'(pos_m)) >> level_m)) & HUE_MASK;
    h6 = hue * 64'd6;
    frac = h6 & HUE_MASK;
    sec = dhcg_pkg::sector_t'(h6[HUE_W+2:HUE_W]);
    v = bright_m;
    p = shade(64'(bright_m), 64'(sat_m), HUE_ONE);
    q = shade(64'(bright_m), 64'(sat_m), frac);
    t = shade(64'(bright_m), 64'(sat_m), HUE_ONE - frac);
    case (sec)
      dhcg_pkg::SEC_RED_YEL: {c.red, c.green, c.blue} = {v, t, p};
      dhcg_pkg::SEC_YEL_GRN: {c.red, c.green, c.blue} = {q, v, p};
      dhcg_pkg::SEC_GRN_CYN: {c.red, c.green, c.blue} = {p, v, t};
      dhcg_pkg::SEC_CYN_BLU: {c.red, c.green, c.blue} = {p, q, v};
      dhcg_pkg::SEC_BLU_MAG: {c.red, c.green, c.blue} = {t, p, v};
      default:               {c.red, c.green, c.blue} = {v, p, q};
    endcase
    c.alpha = alpha_m;
    c.hue = hue[15:0];
    // triad first, then position (odd ones past level one), then level; restart past the last level
    if (triad_m < 2'd2) begin
      triad_m = triad_m + 2'd1;
    end else begin
      triad_m = 2'd0;
      nxt_pos = pos_m + ((level_m == 4'd1) ? 1 : 2);
      if (nxt_pos < (1 << level_m)) begin
        pos_m = nxt_pos[11:0];
      end else if (level_m < LAST_LEVEL) begin
        pos_m = 12'd1;
        level_m = level_m + 4'd1;
      end else begin
        pos_m = 12'd0;
        level_m = 4'd1;
      end
    end
    return c;
  endfunction

  // offer one request beat, maybe after a gap, and wait for the edge taking it
  task automatic push_request(logic req, logic typed, dhcg_pkg::res_t color);
    dhcg_pkg::res_t model_color;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_request <= req;
    do @(posedge clk); while (in_full);
    if (req) begin
      model_color = next_color();
      pending_colors.push_back(typed ? color : model_color);
    end
  endtask

  // stop offering and wait until every color is out and the block is quiet
  task automatic drain();
    in_push <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, mirrored into the model copy
  task automatic write_reg(dhcg_pkg::cfg_reg_t sel, logic [DATA_W-1:0] wd);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= wd;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (sel)
      dhcg_pkg::REG_BASE_HUE:   base_hue_m = wd;
      dhcg_pkg::REG_ALPHA:      alpha_m = wd[7:0];
      dhcg_pkg::REG_SATURATION: sat_m = wd[7:0];
      default:                  bright_m = wd[7:0];
    endcase
  endtask

  // stimulus
  initial begin
    in_push <= 1'b0;
    in_request <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= dhcg_pkg::REG_BASE_HUE;
    cfg_data <= '0;
    rst_n <= 1'b0;
    base_hue_m = 16'd0;
    alpha_m = 8'd255;
    sat_m = 8'd255;
    bright_m = 8'd255;
    triad_m = 2'd0;
    pos_m = 12'd0;
    level_m = 4'd1;
    n_bad = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain();
        write_reg(script[i].reg_sel, script[i].wdata);
      end else begin
        push_request(script[i].req, script[i].typed, script[i].color);
      end
    end

    // random phases, each with fresh register values
    for (int ph = 0; ph < PHASES; ph++) begin
      int served;
      logic req;
      drain();
      for (int r = 0; r < 4; r++) begin
        logic [DATA_W-1:0] wd;
        case ($urandom_range(0, 3))
          0:       wd = '0;
          1:       wd = '1;
          default: wd = DATA_W'($urandom_range(0, 65535));
        endcase
        write_reg(dhcg_pkg::cfg_reg_t'(r), wd);
      end
      gaps_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      served = 0;
      while (served < PHASE_ITEMS) begin
        req = ($urandom_range(0, 7) != 0);
        push_request(req, 1'b0, '0);
        if (req) served++;
      end
    end

    // back to back to the end, no idling on either side
    gaps_on = 1'b0;
    repeat (TAIL_ITEMS) push_request(1'b1, 1'b0, '0);
    drain();

    if (n_bad == 0 && pending_colors.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // color side: random stalls, one long hold-off when asked
  initial begin
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each color beat with the oldest expectation
  always @(posedge clk) begin
    dhcg_pkg::res_t want;
    if (rst_n === 1'b1 && out_pop && !out_empty) begin
      if (pending_colors.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN)
          $display("unexpected color beat: r=%0d g=%0d b=%0d a=%0d hue=%0d",
                   out_red, out_green, out_blue, out_alpha_out, out_hue_out);
      end else begin
        want = pending_colors.pop_front();
        if (out_red !== want.red || out_green !== want.green ||
            out_blue !== want.blue || out_alpha_out !== want.alpha ||
            out_hue_out !== want.hue) begin
          n_bad++;
          // fields in r/g/b/a/hue order
          if (n_bad <= MAX_SHOWN)
            $display("color mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     want.red, want.green, want.blue, want.alpha, want.hue,
                     out_red, out_green, out_blue, out_alpha_out, out_hue_out);
        end
      end
    end
  end

  // watchdog
  initial begin
    #(WATCHDOG);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dhcg_pkg.sv
rtl/core/dhcg_fifo.sv
rtl/core/dhcg_front.sv
rtl/core/dhcg_back.sv
rtl/core/distinct_hue_color_generator_top.sv
verif/distinct_hue_color_generator_top_tb.sv
